>>> design/flanger_fractional_delay_assert.svh
// Assertion macros for the flanger fractional delay block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef FLANGER_FRACTIONAL_DELAY_ASSERT_SVH
`define FLANGER_FRACTIONAL_DELAY_ASSERT_SVH

// Condition in the same cycle implies the consequence in the same cycle.
`define FFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition in one cycle implies the consequence in the next cycle.
`define FFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ffd_pkg.sv
`timescale 1ns / 1ps

package ffd_pkg;

	// delay line geometry
	localparam int DELAY_DEPTH = 4800;
	localparam int FRAC_BITS   = 4;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int POS_W       = ADDR_W + FRAC_BITS;
	localparam int TOTAL       = DELAY_DEPTH * (2 ** FRAC_BITS);
	localparam int WT_W        = FRAC_BITS + 1;

	// field and register widths
	localparam int SAMPLE_W = 16;
	localparam int OFF_W    = 17;
	localparam int GAIN_W   = 32;
	localparam int WORD_W   = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;

	// offset reduction width: holds the raw offset and twice the line length
	localparam int RED_W = (POS_W + 1 > OFF_W) ? POS_W + 1 : OFF_W;

	// shared multiplier and accumulator widths
	localparam int MA_W  = 32;
	localparam int MB_W  = 19;
	localparam int P_W   = MA_W + MB_W;
	localparam int ACC_W = P_W + 1;
	localparam int WET_W = SAMPLE_W + 3;
	localparam int SUM_W = SAMPLE_W + 2;

	// fixed shifts of the mixer
	localparam int MIX_SHIFT   = 15;
	localparam int LEVEL_SHIFT = 12;
	localparam int FB_SHIFT    = 32;

	localparam logic [WT_W-1:0] FRAC_ONE = WT_W'(2 ** FRAC_BITS);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [WORD_W-1:0]   word_t;
	typedef logic [ADDR_W-1:0]          addr_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_OFFSET  = 2'd0,
		REG_FEEDBACK_GAIN = 2'd1,
		REG_MIX           = 2'd2,
		REG_LEVEL         = 2'd3
	} reg_idx_t;

	// register reset values
	localparam logic [OFF_W-1:0]           RST_DELAY_OFFSET  = '0;
	localparam logic signed [GAIN_W-1:0]   RST_FEEDBACK_GAIN = 32'sd33554432;
	localparam logic signed [SAMPLE_W-1:0] RST_MIX           = 16'sd16384;
	localparam logic signed [SAMPLE_W-1:0] RST_LEVEL         = 16'sd4096;

	localparam logic signed [ACC_W-1:0] CLIP_HI = 32767;
	localparam logic signed [ACC_W-1:0] CLIP_LO = -32768;
	localparam logic signed [SAMPLE_W:0] MIX_FULL = 32767;

	// saturate a wide signed value to 16 bits
	function automatic sample_t clip16(input logic signed [ACC_W-1:0] x);
		sample_t r;
		if (x > CLIP_HI) begin
			r = sample_t'(CLIP_HI);
		end else if (x < CLIP_LO) begin
			r = sample_t'(CLIP_LO);
		end else begin
			r = sample_t'(x);
		end
		return r;
	endfunction

endpackage

>>> design/ffd_ifs.sv
`timescale 1ns / 1ps

// input sample channel
interface ffd_in_if import ffd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// output sample channel
interface ffd_out_if import ffd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// register write channel
interface ffd_cfg_if import ffd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output reg_index, output data, input ready);
	modport sink (input valid, input reg_index, input data, output ready);
endinterface

>>> design/flanger_fractional_delay.sv
`timescale 1ns / 1ps

// Flanger delay line: each sample on in_ch is stored in a 4800-word circular line, the line is
// read delay_offset/16 samples behind the write head with linear interpolation, the wet signal
// feeds back into the stored word through feedback_gain, and dry and wet are blended by mix and
// scaled by level into sample_out. A sample steps through the states in turn, with an added
// reduction step when delay_offset is at or above the line length (76800), paced by one shared
// 32x19 multiplier used for all six products and the single read port of the line memory. in_ch
// is ready only between samples; a finished result waits in the output register, so the next
// sample is taken while it is pending. The user writes registers on cfg_ch only while the block
// is idle; the block itself leaves this unchecked, and cfg_ch is always ready. After reset the line
// reads as zero: no clearing pass is run, a fill mark masks words not yet written since reset.
module flanger_fractional_delay import ffd_pkg::*; (
	input logic clk,
	input logic arst_n,
	ffd_in_if.sink    in_ch,
	ffd_out_if.source out_ch,
	ffd_cfg_if.sink   cfg_ch
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_REDUCE = 12'b0000_0000_0010,
		S_RD0    = 12'b0000_0000_0100,
		S_RD1    = 12'b0000_0000_1000,
		S_MUL1   = 12'b0000_0001_0000,
		S_INTERP = 12'b0000_0010_0000,
		S_FB     = 12'b0000_0100_0000,
		S_FBW    = 12'b0000_1000_0000,
		S_MIX    = 12'b0001_0000_0000,
		S_SUM    = 12'b0010_0000_0000,
		S_LVL    = 12'b0100_0000_0000,
		S_OUT    = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [OFF_W-1:0]           delay_offset_q;
	logic signed [GAIN_W-1:0]   feedback_gain_q;
	logic signed [SAMPLE_W-1:0] mix_q;
	logic signed [SAMPLE_W-1:0] level_q;

	// control state
	addr_t wp_q;
	logic  wrapped_q;
	logic  out_valid_q;

	// datapath registers
	sample_t                  dry_q;
	logic [RED_W-1:0]         off_q;
	addr_t                    idx_q;
	addr_t                    nxt_q;
	logic [FRAC_BITS-1:0]     sub_q;
	word_t                    rd_q;
	logic                     rvld_q;
	logic signed [P_W-1:0]    prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [WET_W-1:0]  wet_q;
	logic signed [SUM_W-1:0]  sum_q;
	sample_t                  out_q;

	word_t mem [DELAY_DEPTH];

	logic                    in_acc;
	logic                    out_free;
	addr_t                   wp_next;
	logic [RED_W-1:0]        pos_raw;
	logic [RED_W-1:0]        pos;
	addr_t                   rd_addr;
	logic                    rd_vld;
	logic                    mem_we;
	addr_t                   mem_waddr;
	word_t                   mem_wdata;
	word_t                   word_m;
	logic [WT_W-1:0]         wt0;
	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [P_W-1:0]   prod_d;
	logic signed [P_W-1:0]   fb_adj;
	logic signed [MB_W-1:0]  delta;
	logic signed [ACC_W-1:0] interp;
	sample_t                 interp_c;
	sample_t                 wet_c;
	logic signed [SAMPLE_W:0] dv_wide;
	sample_t                 dv;
	logic signed [ACC_W-1:0] sum_wide;

	assign in_ch.ready    = (state_q == S_IDLE);
	assign in_acc         = in_ch.valid && in_ch.ready;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_q;
	assign cfg_ch.ready   = 1'b1;
	assign out_free       = !out_valid_q || out_ch.ready;

	// advance the write head with wrap
	assign wp_next = (wp_q == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp_q + addr_t'(1);

	// read position: write head minus reduced offset, folded into the line
	assign pos_raw = RED_W'({wp_q, {FRAC_BITS{1'b0}}}) + RED_W'(TOTAL) - off_q;
	assign pos     = (pos_raw >= RED_W'(TOTAL)) ? pos_raw - RED_W'(TOTAL) : pos_raw;

	// read address and fill mark check
	assign rd_addr = (state_q == S_RD0) ? idx_q : nxt_q;
	assign rd_vld  = wrapped_q || ((rd_addr != '0) && (rd_addr <= wp_q));
	assign word_m  = rvld_q ? rd_q : '0;
	assign wt0     = FRAC_ONE - WT_W'(sub_q);

	// feedback product truncated toward zero
	assign fb_adj = prod_q + (prod_q[P_W-1] ? P_W'({FB_SHIFT{1'b1}}) : '0);
	assign delta  = fb_adj[P_W-1:FB_SHIFT];

	// interpolation sum and wet value
	assign interp   = acc_q + ACC_W'(prod_q);
	assign interp_c = clip16(interp >>> FRAC_BITS);
	assign wet_c    = clip16(ACC_W'(wet_q));

	// dry level from mix magnitude
	assign dv_wide = (mix_q > 0) ? MIX_FULL - (SAMPLE_W + 1)'(mix_q)
	                             : MIX_FULL + (SAMPLE_W + 1)'(mix_q);
	assign dv      = sample_t'(dv_wide);

	assign sum_wide = acc_q + ACC_W'(prod_q >>> MIX_SHIFT);

	// memory write port: dry sample on accept, feedback word later
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = WORD_W'(dry_q) + WORD_W'(delta);
		if (in_acc) begin
			mem_we    = 1'b1;
			mem_waddr = wp_next;
			mem_wdata = WORD_W'(in_ch.sample_in);
		end else if (state_q == S_FBW) begin
			mem_we = 1'b1;
		end
	end

	// select operands of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_RD1: begin
				mul_a = word_m;
				mul_b = signed'(MB_W'(wt0));
			end
			S_MUL1: begin
				mul_a = word_m;
				mul_b = signed'(MB_W'(sub_q));
			end
			S_FB: begin
				mul_a = feedback_gain_q;
				mul_b = wet_q;
			end
			S_FBW: begin
				mul_a = MA_W'(dry_q);
				mul_b = MB_W'(dv);
			end
			S_MIX: begin
				mul_a = MA_W'(wet_c);
				mul_b = MB_W'(mix_q);
			end
			// keep the level product while the result waits
			S_LVL, S_OUT: begin
				mul_a = MA_W'(level_q);
				mul_b = MB_W'(sum_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// line memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_offset_q  <= RST_DELAY_OFFSET;
			feedback_gain_q <= RST_FEEDBACK_GAIN;
			mix_q           <= RST_MIX;
			level_q         <= RST_LEVEL;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (reg_idx_t'(cfg_ch.reg_index))
				REG_DELAY_OFFSET:  delay_offset_q  <= cfg_ch.data[OFF_W-1:0];
				REG_FEEDBACK_GAIN: feedback_gain_q <= signed'(cfg_ch.data[GAIN_W-1:0]);
				REG_MIX:           mix_q           <= signed'(cfg_ch.data[SAMPLE_W-1:0]);
				REG_LEVEL:         level_q         <= signed'(cfg_ch.data[SAMPLE_W-1:0]);
				default: ;
			endcase
		end
	end

	// sequence one sample through the shared unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						wp_q    <= wp_next;
						state_q <= S_REDUCE;
						if (wp_next == '0) begin
							wrapped_q <= 1'b1;
						end
					end
				end
				S_REDUCE: begin
					if (off_q < RED_W'(TOTAL)) begin
						state_q <= S_RD0;
					end
				end
				S_RD0:    state_q <= S_RD1;
				S_RD1:    state_q <= S_MUL1;
				S_MUL1:   state_q <= S_INTERP;
				S_INTERP: state_q <= S_FB;
				S_FB:     state_q <= S_FBW;
				S_FBW:    state_q <= S_MIX;
				S_MIX:    state_q <= S_SUM;
				S_SUM:    state_q <= S_LVL;
				S_LVL:    state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// advance the datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		rvld_q <= rd_vld;
		case (state_q)
			S_IDLE: begin
				dry_q <= in_ch.sample_in;
				off_q <= RED_W'(delay_offset_q);
			end
			S_REDUCE: begin
				if (off_q >= RED_W'(TOTAL)) begin
					off_q <= off_q - RED_W'(TOTAL);
				end else begin
					idx_q <= pos[POS_W-1:FRAC_BITS];
					sub_q <= pos[FRAC_BITS-1:0];
				end
			end
			S_RD0: begin
				nxt_q <= (idx_q == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : idx_q + addr_t'(1);
			end
			S_MUL1: begin
				acc_q <= ACC_W'(prod_q);
			end
			S_INTERP: begin
				wet_q <= signed'({interp_c, 3'b000});
			end
			S_MIX: begin
				acc_q <= ACC_W'(prod_q >>> MIX_SHIFT);
			end
			S_SUM: begin
				sum_q <= sum_wide[SUM_W-1:0];
			end
			S_OUT: begin
				if (out_free) begin
					out_q <= clip16(ACC_W'(prod_q >>> LEVEL_SHIFT));
				end
			end
			default: ;
		endcase
	end

`include "flanger_fractional_delay_assert.svh"

	`FFD_ASSERT_NOW(a_wp_in_line, 1'b1, wp_q <= addr_t'(DELAY_DEPTH - 1), "write head beyond line")
	`FFD_ASSERT_NOW(a_idx_in_line, state_q == S_RD0, idx_q <= addr_t'(DELAY_DEPTH - 1), "read index beyond line")
	`FFD_ASSERT_NEXT(a_fill_sticky, wrapped_q, wrapped_q, "fill mark dropped")
	`FFD_ASSERT_NEXT(a_result_posted, (state_q == S_OUT) && out_free, out_valid_q && (state_q == S_IDLE), "result not posted")

endmodule
